### hw/rtl/apvc_pkg.sv
// ----------------------------------------------------------------------------
// apvc_pkg: shared types and constants for the PID velocity command block
// Holds the item payload types, register indexes, direction codes and the
// arithmetic widths used by every stage of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

package apvc_pkg;

  // Positions are taken as PosWidth-bit two's complement from their low bits.
  localparam int PosWidth = 32;
  localparam int FieldW   = 32;

  localparam int GainW    = 16;
  localparam int PowerW   = 8;
  localparam int VelW     = 9;
  localparam int IntegW   = 32;

  // Error and position change are exact at one bit more than a position.
  localparam int ErrW     = PosWidth + 1;
  localparam int WideW    = (ErrW > IntegW) ? ErrW : IntegW;
  localparam int AccW     = WideW + 1;
  localparam int ProdW    = GainW + WideW;
  // Three products summed, then the rounding half added.
  localparam int SumW     = ProdW + 2;
  localparam int RndW     = SumW + 1;
  localparam int FracW    = 8;
  localparam int QuotW    = RndW - FracW;

  // Configuration register indexes.
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgPropGain  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIntegGain = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDerivGain = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxPower  = 2'd3;

  localparam logic [PowerW-1:0] MaxPowerReset = 8'd255;

  typedef enum logic [1:0] {
    DirPause = 2'd0,
    DirFwd   = 2'd1,
    DirBack  = 2'd2
  } dir_e;

  typedef struct packed {
    logic                     kind;
    logic signed [FieldW-1:0] target_pos;
    logic signed [FieldW-1:0] measured_pos;
    logic signed [FieldW-1:0] prior_pos;
  } in_item_t;

  typedef struct packed {
    logic signed [VelW-1:0] velocity;
    logic [PowerW-1:0]      magnitude;
    dir_e                   direction;
    logic                   commit;
  } out_item_t;

  // Error terms handed from the integrator to the multiply stage.
  typedef struct packed {
    logic                     clear;
    logic signed [ErrW-1:0]   err;
    logic signed [ErrW-1:0]   dpos;
    logic signed [IntegW-1:0] integ;
  } terms_t;

  // Registered gain products handed to the output shaping.
  typedef struct packed {
    logic                    clear;
    logic signed [ProdW-1:0] p_term;
    logic signed [ProdW-1:0] i_term;
    logic signed [ProdW-1:0] d_term;
  } prods_t;

endpackage

`default_nettype wire

### hw/rtl/apvc_integ.sv
// ----------------------------------------------------------------------------
// apvc_integ: position error and saturating integrator
// Forms the error and position change of an item and keeps the 32-bit
// integral, which saturates at the signed limits and is cleared on request.
// ----------------------------------------------------------------------------
`default_nettype none

module apvc_integ (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  apvc_pkg::in_item_t item_i,
  output apvc_pkg::terms_t  terms_o
);
  import apvc_pkg::*;

  logic signed [IntegW-1:0] integ_q, integ_d;
  logic signed [ErrW-1:0]   tgt, act, pri;
  logic signed [ErrW-1:0]   err, dpos;
  logic signed [AccW-1:0]   acc;
  logic                     ovf;
  logic signed [IntegW-1:0] integ_sat;

  assign tgt  = ErrW'($signed(item_i.target_pos[PosWidth-1:0]));
  assign act  = ErrW'($signed(item_i.measured_pos[PosWidth-1:0]));
  assign pri  = ErrW'($signed(item_i.prior_pos[PosWidth-1:0]));
  assign err  = tgt - act;
  assign dpos = act - pri;

  assign acc = AccW'(integ_q) + AccW'(err);

  // The sum fits when every bit above the result's sign bit matches it.
  assign ovf = !((&acc[AccW-1:IntegW-1]) || !(|acc[AccW-1:IntegW-1]));

  always_comb begin
    if (ovf) begin
      integ_sat = acc[AccW-1] ? {1'b1, {(IntegW-1){1'b0}}} : {1'b0, {(IntegW-1){1'b1}}};
    end else begin
      integ_sat = acc[IntegW-1:0];
    end
  end

  always_comb begin
    integ_d = integ_q;
    if (step_i) begin
      integ_d = item_i.kind ? '0 : integ_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else begin
      integ_q <= integ_d;
    end
  end

  assign terms_o.clear = item_i.kind;
  assign terms_o.err   = err;
  assign terms_o.dpos  = dpos;
  assign terms_o.integ = integ_d;

endmodule

`default_nettype wire

### hw/rtl/apvc_shape.sv
// ----------------------------------------------------------------------------
// apvc_shape: sum, rounding and clamp of the gain products
// Adds the three Q41.8 products, rounds by adding one half and truncating
// toward zero, and clamps to plus or minus the power limit.
// ----------------------------------------------------------------------------
`default_nettype none

module apvc_shape (
  input  apvc_pkg::prods_t                    prods_i,
  input  logic [apvc_pkg::PowerW-1:0]         max_power_i,
  output logic signed [apvc_pkg::VelW-1:0]    velocity_o
);
  import apvc_pkg::*;

  logic signed [SumW-1:0]  sum;
  logic signed [RndW-1:0]  rnd;
  logic signed [RndW-1:0]  biased;
  logic signed [QuotW-1:0] quot;
  logic signed [QuotW-1:0] lim;

  assign sum = SumW'(prods_i.p_term) + SumW'(prods_i.i_term) + SumW'(prods_i.d_term);
  assign rnd = RndW'(sum) + RndW'(128);

  // A negative value gets 255 added first so the arithmetic shift truncates
  // toward zero instead of toward minus infinity.
  assign biased = rnd[RndW-1] ? (rnd + RndW'(255)) : rnd;
  assign quot   = QuotW'(biased >>> FracW);
  assign lim    = QuotW'($signed({1'b0, max_power_i}));

  always_comb begin
    if (quot > lim) begin
      velocity_o = VelW'(lim);
    end else if (quot < -lim) begin
      velocity_o = VelW'(-lim);
    end else begin
      velocity_o = VelW'(quot);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/axis_pid_velocity_command.sv
// ----------------------------------------------------------------------------
// axis_pid_velocity_command: PID position controller with velocity output
// Turns each control item into a clamped signed drive command, its magnitude
// and direction, and a commit flag when the held command changes.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   input     in         in_valid_i/in_stall_o  in_data_i   (apvc_pkg::in_item_t)
//   result    out        out_valid_o/out_stall_i out_data_o (apvc_pkg::out_item_t)
//   config    in         cfg_we_i               cfg_idx_i, cfg_data_i
//
// The block is a four-stage pipeline: input register, integrator, gain
// multiply and output register. It accepts one item per cycle unless stalled;
// an item passes the input, error-term and product registers in turn before
// the output register presents its result. The integrator, multiplies and sum
// with clamp each sit in their own stage: none holds a long arithmetic chain.
// The integral and the held velocity are each updated in a single stage, so
// back-to-back items see each other's state with no hazard.
// A stall on the result side holds the output register; stages behind it keep
// filling until the pipeline is full, and only then is the input stalled.
// Reset clears the valid bits, the integral, the held velocity and the gains;
// the power limit resets to its full value of 255.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_pid_velocity_command (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  apvc_pkg::in_item_t                in_data_i,

  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output apvc_pkg::out_item_t               out_data_o,

  input  logic                              cfg_we_i,
  input  logic [apvc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [apvc_pkg::GainW-1:0]        cfg_data_i
);
  import apvc_pkg::*;

  // Configuration registers.
  logic signed [GainW-1:0] prop_gain_q, integ_gain_q, deriv_gain_q;
  logic [PowerW-1:0]       max_power_q;

  // Pipeline valid bits and payload registers.
  logic      v1_q, v2_q, v3_q, v4_q;
  in_item_t  item1_q;
  terms_t    terms2_q;
  prods_t    prods3_q;
  out_item_t out_q;

  logic signed [VelW-1:0] last_vel_q;

  // Advance and ready signals walk back from the output register.
  logic ready1, ready2, ready3, ready4;
  logic accept, adv1, adv2, adv3;

  terms_t                 terms_next;
  prods_t                 prods_next;
  logic signed [VelW-1:0] shaped_vel;
  logic signed [VelW-1:0] vel;
  out_item_t              out_next;

  assign ready4 = !v4_q || !out_stall_i;
  assign adv3   = v3_q && ready4;
  assign ready3 = !v3_q || ready4;
  assign adv2   = v2_q && ready3;
  assign ready2 = !v2_q || ready3;
  assign adv1   = v1_q && ready2;
  assign ready1 = !v1_q || ready2;
  assign accept = in_valid_i && ready1;

  assign in_stall_o  = !ready1;
  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

  // Configuration writes must only be made while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= '0;
      integ_gain_q <= '0;
      deriv_gain_q <= '0;
      max_power_q  <= MaxPowerReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPropGain:  prop_gain_q  <= cfg_data_i;
        CfgIntegGain: integ_gain_q <= cfg_data_i;
        CfgDerivGain: deriv_gain_q <= cfg_data_i;
        CfgMaxPower:  max_power_q  <= cfg_data_i[PowerW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= accept || (v1_q && !adv1);
      v2_q <= adv1 || (v2_q && !adv2);
      v3_q <= adv2 || (v3_q && !adv3);
      v4_q <= adv3 || (v4_q && out_stall_i);
    end
  end

  // Stage 1: input register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item1_q <= in_data_i;
    end
  end

  // Stage 2: error terms and the integral, which updates as the item leaves
  // the input register.
  apvc_integ u_integ (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (adv1),
    .item_i  (item1_q),
    .terms_o (terms_next)
  );

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      terms2_q <= terms_next;
    end
  end

  // Stage 3: the three gain products, each registered.
  assign prods_next.clear  = terms2_q.clear;
  assign prods_next.p_term = ProdW'(prop_gain_q * terms2_q.err);
  assign prods_next.i_term = ProdW'(integ_gain_q * terms2_q.integ);
  assign prods_next.d_term = ProdW'(deriv_gain_q * terms2_q.dpos);

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      prods3_q <= prods_next;
    end
  end

  // Stage 4: sum, round, clamp, then compare with the held velocity.
  apvc_shape u_shape (
    .prods_i     (prods3_q),
    .max_power_i (max_power_q),
    .velocity_o  (shaped_vel)
  );

  // A clear item reports the held velocity and never commits.
  assign vel = prods3_q.clear ? last_vel_q : shaped_vel;

  always_comb begin
    out_next.velocity  = vel;
    out_next.magnitude = vel[VelW-1] ? PowerW'(-vel) : vel[PowerW-1:0];
    if (vel[VelW-1]) begin
      out_next.direction = DirBack;
    end else if (vel == '0) begin
      out_next.direction = DirPause;
    end else begin
      out_next.direction = DirFwd;
    end
    out_next.commit = !prods3_q.clear && (shaped_vel != last_vel_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_vel_q <= '0;
    end else if (adv3 && !prods3_q.clear) begin
      last_vel_q <= shaped_vel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      out_q <= out_next;
    end
  end

endmodule

`default_nettype wire

### tb/apvc_velocity_checker.sv
// ----------------------------------------------------------------------------
// apvc_velocity_checker: result checker for the PID velocity command block
// Watches the configuration port and both item channels, keeps its own copy
// of the gains, the integral and the held velocity, predicts the drive
// command for every accepted item and compares it with the returned item.
// ----------------------------------------------------------------------------

module apvc_velocity_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  apvc_pkg::in_item_t             in_data_i,

  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  apvc_pkg::out_item_t            out_data_i,

  input  logic                           cfg_we_i,
  input  logic [apvc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [apvc_pkg::GainW-1:0]     cfg_data_i,

  output int                             fail_count_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import apvc_pkg::*;

  localparam longint IntegMax = 64'sd2147483647;
  localparam longint IntegMin = -64'sd2147483648;

  longint    kp;
  longint    ki;
  longint    kd;
  logic [PowerW-1:0] power_cap;
  longint    integ_sum;
  longint    held_vel;
  out_item_t awaited_cmds[$];
  int        mismatches = 0;
  int        waiting    = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;

  // Advances the integral and the held velocity by one item and returns the
  // command the block should report for it.
  function automatic out_item_t next_command(input in_item_t item);
    out_item_t cmd;
    longint    err;
    longint    dpos;
    longint    acc;
    longint    scaled;
    longint    vel;
    logic      changed;
    if (item.kind) begin
      integ_sum = 0;
      vel       = held_vel;
      changed   = 1'b0;
    end else begin
      err  = longint'(item.target_pos) - longint'(item.measured_pos);
      dpos = longint'(item.measured_pos) - longint'(item.prior_pos);
      acc  = integ_sum + err;
      if (acc > IntegMax) acc = IntegMax;
      else if (acc < IntegMin) acc = IntegMin;
      integ_sum = acc;
      // Add one half to the Q56.8 sum and truncate toward zero, then clamp.
      scaled = kp * err + ki * integ_sum + kd * dpos + 128;
      vel = (scaled >= 0) ? (scaled >>> 8) : -((-scaled) >>> 8);
      if (vel > longint'(power_cap)) vel = longint'(power_cap);
      else if (vel < -longint'(power_cap)) vel = -longint'(power_cap);
      changed  = (vel != held_vel);
      held_vel = vel;
    end
    cmd.velocity  = VelW'(vel);
    cmd.magnitude = PowerW'((vel < 0) ? -vel : vel);
    cmd.direction = (vel > 0) ? DirFwd : ((vel < 0) ? DirBack : DirPause);
    cmd.commit    = changed;
    return cmd;
  endfunction

  task automatic flag_field(input string field, input longint want, input longint got);
    $display("%t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      kp        = 0;
      ki        = 0;
      kd        = 0;
      power_cap = MaxPowerReset;
      integ_sum = 0;
      held_vel  = 0;
      awaited_cmds.delete();
      waiting  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgPropGain:  kp = longint'($signed(cfg_data_i));
          CfgIntegGain: ki = longint'($signed(cfg_data_i));
          CfgDerivGain: kd = longint'($signed(cfg_data_i));
          CfgMaxPower:  power_cap = cfg_data_i[PowerW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_cmds.size() == 0) begin
          $display("%t: unexpected item, expected none, actual velocity %0d", $time,
                   $signed(out_data_i.velocity));
          mismatches++;
        end else begin
          want = awaited_cmds.pop_front();
          if (out_data_i.velocity !== want.velocity)
            flag_field("velocity", $signed(want.velocity), $signed(out_data_i.velocity));
          if (out_data_i.magnitude !== want.magnitude)
            flag_field("magnitude", want.magnitude, out_data_i.magnitude);
          if (out_data_i.direction !== want.direction)
            flag_field("direction", want.direction, out_data_i.direction);
          if (out_data_i.commit !== want.commit)
            flag_field("commit", want.commit, out_data_i.commit);
        end
      end
      if (in_valid_i && !in_stall_i) awaited_cmds.push_back(next_command(in_data_i));
      waiting <= awaited_cmds.size();
    end
  end

endmodule

### tb/axis_pid_velocity_command_tb.sv
// ----------------------------------------------------------------------------
// axis_pid_velocity_command_tb: testbench for the PID velocity command block
// Drives directed and random control items under several gain and power
// settings with random gaps and output stalls; a checker beside the block
// predicts every drive command and counts mismatches for the verdict.
// ----------------------------------------------------------------------------

module axis_pid_velocity_command_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import apvc_pkg::*;

  // Cycles with no item moving on either channel before the run is declared
  // hung. Random gaps and stalls are short; config writes cover four registers.
  localparam int StallLimit     = 2000;
  localparam int RandomPerPhase = 100;
  localparam int TailCycles     = 8;
  localparam int PosMax         = 32'sh7FFF_FFFF;
  localparam int PosMin         = 32'sh8000_0000;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = CfgPropGain;
  logic [GainW-1:0]    cfg_data  = '0;
  logic                quiet     = 1'b0;
  int                  fail_count;
  int                  pending;
  int                  idle_cycles = 0;

  axis_pid_velocity_command uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  apvc_velocity_checker command_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side stalls with a chance of about one in five, except in the
  // quiet phase, where items must stream through back to back.
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 20);
  end

  // Any accepted item on either channel restarts the hang counter.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("axis_pid_velocity_command_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t ctrl_item(input int target, input int actual, input int prior);
    in_item_t item;
    item.kind         = 1'b0;
    item.target_pos   = target;
    item.measured_pos = actual;
    item.prior_pos    = prior;
    return item;
  endfunction

  function automatic in_item_t clear_item();
    in_item_t item;
    item      = '0;
    item.kind = 1'b1;
    return item;
  endfunction

  // Most items model a real axis: target and prior sample close to the
  // current count, so the command stays inside the clamp often enough to
  // exercise rounding and commit. One in four uses fully random positions,
  // which also toggles every position bit and the wide error paths.
  function automatic in_item_t random_item();
    in_item_t    item;
    logic [31:0] base;
    item.kind = ($urandom_range(0, 99) < 8);
    base      = $urandom();
    if ($urandom_range(0, 3) == 0) begin
      item.target_pos   = $urandom();
      item.measured_pos = $urandom();
      item.prior_pos    = $urandom();
    end else begin
      item.measured_pos = base;
      item.target_pos   = base + $urandom_range(0, 600) - 300;
      item.prior_pos    = base + $urandom_range(0, 60) - 30;
    end
    return item;
  endfunction

  // A gain of roughly -1.2 to +1.2 in Q8.8.
  function automatic logic [GainW-1:0] modest_gain();
    return GainW'($urandom_range(0, 600) - 300);
  endfunction

  // Presents one item, with an optional random gap in front of it, and
  // returns at the edge where it is accepted. Valid stays high on return so
  // that the next item can follow without a bubble.
  task automatic send_item(input in_item_t item);
    while (!quiet && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drops valid and waits until every predicted command has come back, so
  // the block is idle for a register write.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic load_gains(input logic [GainW-1:0] prop, input logic [GainW-1:0] integ,
                            input logic [GainW-1:0] deriv, input logic [PowerW-1:0] cap);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgPropGain;
    cfg_data <= prop;
    @(posedge clk);
    cfg_idx  <= CfgIntegGain;
    cfg_data <= integ;
    @(posedge clk);
    cfg_idx  <= CfgDerivGain;
    cfg_data <= deriv;
    @(posedge clk);
    cfg_idx  <= CfgMaxPower;
    cfg_data <= GainW'(cap);
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset gains are zero, so even a large error must give a pause command.
    send_item(ctrl_item(1000, 0, 0));
    send_item(clear_item());

    // Unity proportional gain: small, repeated, clamped and wide errors. The
    // three full-scale errors drive the integral into both saturation limits.
    settle();
    load_gains(16'sd256, 16'sd0, 16'sd0, 8'd255);
    send_item(ctrl_item(0, 0, 0));
    send_item(ctrl_item(100, 0, 0));
    send_item(ctrl_item(100, 0, 0));
    send_item(ctrl_item(1000, 0, 0));
    send_item(ctrl_item(0, 1000, 1000));
    send_item(ctrl_item(PosMax, PosMin, PosMin));
    send_item(ctrl_item(PosMin, PosMax, PosMax));
    send_item(ctrl_item(PosMin, PosMax, PosMax));
    send_item(clear_item());

    // Smallest gain step: the rounding boundaries on both signs.
    settle();
    load_gains(16'sd1, 16'sd0, 16'sd0, 8'd255);
    send_item(ctrl_item(127, 0, 0));
    send_item(ctrl_item(128, 0, 0));
    send_item(ctrl_item(-128, 0, 0));
    send_item(ctrl_item(-129, 0, 0));
    send_item(ctrl_item(-384, 0, 0));

    // Derivative alone, including a full-scale position change.
    settle();
    load_gains(16'sd0, 16'sd0, 16'sd256, 8'd255);
    send_item(ctrl_item(0, 0, 50));
    send_item(ctrl_item(0, PosMax, PosMin));

    // Integral alone: the clear first, so the sum builds from zero.
    settle();
    load_gains(16'sd0, 16'sd256, 16'sd0, 8'd255);
    send_item(clear_item());
    send_item(ctrl_item(10, 0, 0));
    send_item(ctrl_item(10, 0, 0));

    // Extreme gains with a zero power limit must always pause.
    settle();
    load_gains(16'sh7FFF, 16'sh8000, 16'sh7FFF, 8'd0);
    send_item(ctrl_item(1000, 0, 5));
    send_item(ctrl_item(-5, 7, 3));

    // Opposite extremes with full power.
    settle();
    load_gains(16'sh8000, 16'sh7FFF, 16'sh8000, 8'd255);
    send_item(ctrl_item(3, 1, 0));
    send_item(clear_item());

    // Random items under a series of settings. The last phase runs with no
    // gaps and no stalls at all.
    for (int phase = 0; phase < 5; phase++) begin
      settle();
      case (phase)
        0: load_gains(modest_gain(), modest_gain(), modest_gain(), PowerW'($urandom_range(1, 255)));
        1: load_gains(16'sh7FFF, 16'sh8000, 16'sh7FFF, 8'd255);
        2: load_gains(modest_gain(), modest_gain(), modest_gain(), 8'd0);
        3: load_gains(GainW'($urandom()), GainW'($urandom()), GainW'($urandom()),
                      PowerW'($urandom()));
        default: begin
          quiet <= 1'b1;
          load_gains(modest_gain(), modest_gain(), modest_gain(), 8'd255);
        end
      endcase
      repeat (RandomPerPhase) send_item(random_item());
    end

    settle();
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("axis_pid_velocity_command_tb: clean");
    else
      $display("axis_pid_velocity_command_tb: errors");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/apvc_pkg.sv
hw/rtl/apvc_integ.sv
hw/rtl/apvc_shape.sv
hw/rtl/axis_pid_velocity_command.sv
tb/apvc_velocity_checker.sv
tb/axis_pid_velocity_command_tb.sv
